// ===== src/srs_pkg.sv =====
// Shared types and constants for the sequence read statistics unit.
package srs_pkg;

  localparam int LEN_W       = 32;
  localparam int BASE_W      = 48;
  localparam int READ_W      = 32;
  localparam int WARN_W      = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_NL   = 8'd10;
  localparam logic [7:0] CH_AT   = 8'd64;
  localparam logic [7:0] CH_GT   = 8'd62;
  localparam logic [7:0] CH_PLUS = 8'd43;

  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_END  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [READ_W-1:0] read_count;
    logic [BASE_W-1:0] base_count;
    logic [LEN_W-1:0]  shortest_read;
    logic [LEN_W-1:0]  longest_read;
    logic [WARN_W-1:0] warning_count;
  } out_word_t;

  // One finished line, or end of stream with an optional unterminated line.
  typedef struct packed {
    logic             eos;
    logic             has_line;
    logic             is_at;
    logic             is_gt;
    logic             plus_only;
    logic [LEN_W-1:0] len;
  } line_evt_t;

endpackage

// ===== src/srs_front.sv =====
// Front end: takes bytes, tracks the open line and emits line events.
module srs_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  srs_pkg::in_word_t in_data,
  input  logic             q_full,
  output logic             evt_valid,
  output srs_pkg::line_evt_t evt
);
  import srs_pkg::*;

  logic             at_start_r, at_start_nxt;
  logic [7:0]       first_r, first_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             acc;
  logic             is_end;
  logic             is_nl;

  assign full   = q_full;
  assign acc    = push && !q_full;
  assign is_end = (in_data.action == ACT_END);
  assign is_nl  = (in_data.data_byte == CH_NL);

  always_comb begin
    evt.eos       = is_end;
    evt.has_line  = is_end ? !at_start_r : 1'b1;
    evt.is_at     = !at_start_r && (first_r == CH_AT);
    evt.is_gt     = !at_start_r && (first_r == CH_GT);
    evt.plus_only = !at_start_r && (first_r == CH_PLUS) && (len_r == LEN_W'(1));
    evt.len       = len_r;
    evt_valid     = acc && (is_end || is_nl);
  end

  always_comb begin
    at_start_nxt = at_start_r;
    first_nxt    = first_r;
    len_nxt      = len_r;
    if (acc) begin
      if (is_end || is_nl) begin
        at_start_nxt = 1'b1;
        first_nxt    = '0;
        len_nxt      = '0;
      end else begin
        if (at_start_r) begin
          first_nxt    = in_data.data_byte;
          at_start_nxt = 1'b0;
        end
        // hold at all ones
        if (!(&len_r)) begin
          len_nxt = len_r + LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
      first_r    <= '0;
      len_r      <= '0;
    end else begin
      at_start_r <= at_start_nxt;
      first_r    <= first_nxt;
      len_r      <= len_nxt;
    end
  end

endmodule

// ===== src/srs_fifo.sv =====
// Short queue of line events between the front and back ends.
module srs_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  srs_pkg::line_evt_t wr_data,
  output logic               full,
  input  logic               rd_en,
  output srs_pkg::line_evt_t rd_data,
  output logic               empty
);
  import srs_pkg::*;

  line_evt_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_wr;
  logic              do_rd;

  assign full    = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_wr ? wptr_r + QPTR_W'(1) : wptr_r;
    rptr_nxt = do_rd ? rptr_r + QPTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== src/srs_back.sv =====
// Back end: applies line events to the read statistics and holds the result.
module srs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                evt_valid,
  input  srs_pkg::line_evt_t  evt,
  output logic                evt_pop,
  output logic                empty,
  input  logic                pop,
  output srs_pkg::out_word_t  out_data
);
  import srs_pkg::*;

  typedef enum logic [1:0] {FMT_NONE, FMT_FASTA, FMT_FASTQ} fmt_t;
  typedef enum logic [1:0] {PH_HDR, PH_SEQ, PH_QUAL} phase_t;

  fmt_t              fmt_r, fmt_nxt;
  phase_t            ph_r, ph_nxt;
  logic [LEN_W-1:0]  rlen_r, rlen_nxt;
  logic [LEN_W-1:0]  qrem_r, qrem_nxt;
  logic              chk_r, chk_nxt;
  logic [READ_W-1:0] reads_r, reads_nxt;
  logic [BASE_W-1:0] bases_r, bases_nxt;
  logic [LEN_W-1:0]  min_r, min_nxt;
  logic [LEN_W-1:0]  max_r, max_nxt;
  logic [WARN_W-1:0] warn_r, warn_nxt;
  logic              out_valid_r;
  out_word_t         out_data_r;
  out_word_t         result;
  logic              take;
  logic [BASE_W:0]   bsum;
  logic [LEN_W:0]    rsum;

  assign take     = evt_valid && (!evt.eos || !out_valid_r || pop);
  assign evt_pop  = take;
  assign empty    = !out_valid_r;
  assign out_data = out_data_r;

  always_comb begin
    fmt_nxt   = fmt_r;
    ph_nxt    = ph_r;
    rlen_nxt  = rlen_r;
    qrem_nxt  = qrem_r;
    chk_nxt   = chk_r;
    reads_nxt = reads_r;
    bases_nxt = bases_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    warn_nxt  = warn_r;
    bsum      = {1'b0, bases_r} + (BASE_W+1)'(evt.len);
    rsum      = {1'b0, rlen_r} + {1'b0, evt.len};
    result    = '0;

    if (take && evt.has_line) begin
      unique case (fmt_r)
        FMT_NONE: begin
          if (!(&reads_r)) reads_nxt = reads_r + READ_W'(1);
          rlen_nxt = '0;
          if (evt.is_at) begin
            fmt_nxt = FMT_FASTQ;
            ph_nxt  = PH_SEQ;
          end else begin
            fmt_nxt = FMT_FASTA;
          end
        end
        FMT_FASTA: begin
          if (evt.is_gt) begin
            if (!(&reads_r)) reads_nxt = reads_r + READ_W'(1);
            if (rlen_r < min_nxt) min_nxt = rlen_r;
            if (rlen_r > max_nxt) max_nxt = rlen_r;
            rlen_nxt = '0;
          end else begin
            bases_nxt = bsum[BASE_W] ? '1 : bsum[BASE_W-1:0];
            rlen_nxt  = rsum[LEN_W] ? '1 : rsum[LEN_W-1:0];
          end
        end
        default: begin
          unique case (ph_r)
            PH_HDR: begin
              if (chk_r && !evt.is_at && !(&warn_r)) warn_nxt = warn_r + WARN_W'(1);
              chk_nxt = 1'b0;
              if (!(&reads_r)) reads_nxt = reads_r + READ_W'(1);
              ph_nxt = PH_SEQ;
            end
            PH_SEQ: begin
              if (evt.plus_only) begin
                qrem_nxt = rlen_r;
                ph_nxt   = PH_QUAL;
              end else begin
                bases_nxt = bsum[BASE_W] ? '1 : bsum[BASE_W-1:0];
                rlen_nxt  = rsum[LEN_W] ? '1 : rsum[LEN_W-1:0];
              end
            end
            default: begin
              if (evt.len >= qrem_r) begin
                qrem_nxt = '0;
                if (rlen_r < min_nxt) min_nxt = rlen_r;
                if (rlen_r > max_nxt) max_nxt = rlen_r;
                rlen_nxt = '0;
                chk_nxt  = 1'b1;
                ph_nxt   = PH_HDR;
              end else begin
                qrem_nxt = qrem_r - evt.len;
              end
            end
          endcase
        end
      endcase
    end

    if (take && evt.eos) begin
      // close the open read, then start over for the next stream
      if (fmt_nxt == FMT_FASTA || (fmt_nxt == FMT_FASTQ && ph_nxt == PH_QUAL)) begin
        if (rlen_nxt < min_nxt) min_nxt = rlen_nxt;
        if (rlen_nxt > max_nxt) max_nxt = rlen_nxt;
      end
      result.read_count    = reads_nxt;
      result.base_count    = bases_nxt;
      result.shortest_read = min_nxt;
      result.longest_read  = max_nxt;
      result.warning_count = warn_nxt;
      fmt_nxt   = FMT_NONE;
      ph_nxt    = PH_HDR;
      rlen_nxt  = '0;
      qrem_nxt  = '0;
      chk_nxt   = 1'b0;
      reads_nxt = '0;
      bases_nxt = '0;
      min_nxt   = '1;
      max_nxt   = '0;
      warn_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_NONE;
      ph_r    <= PH_HDR;
      rlen_r  <= '0;
      qrem_r  <= '0;
      chk_r   <= 1'b0;
      reads_r <= '0;
      bases_r <= '0;
      min_r   <= '1;
      max_r   <= '0;
      warn_r  <= '0;
    end else begin
      fmt_r   <= fmt_nxt;
      ph_r    <= ph_nxt;
      rlen_r  <= rlen_nxt;
      qrem_r  <= qrem_nxt;
      chk_r   <= chk_nxt;
      reads_r <= reads_nxt;
      bases_r <= bases_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      warn_r  <= warn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && evt.eos) begin
      out_valid_r <= 1'b1;
    end else if (pop && out_valid_r) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && evt.eos) begin
      out_data_r <= result;
    end
  end

endmodule

// ===== src/sequence_read_statistics_unit.sv =====
// Sequence read statistics unit: FASTA/FASTQ byte stream in, one summary word out.
// Takes one byte word per cycle while full is low. A word with action set ends the
// stream; its summary (read and base counts, shortest and longest read, FASTQ
// warnings) shows on out_data once the line event, written to the four-entry
// queue when that word is accepted, is taken by the back end's statistics update,
// which loads the summary register; an earlier summary must be popped first.
// full rises only when that queue is full, which happens only while an end of
// stream event waits behind a summary that has not been popped and more lines
// end; the back end otherwise retires one line event per cycle.
// The unit then starts over from its reset state for the next stream.
module sequence_read_statistics_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  srs_pkg::in_word_t  in_data,
  output logic               empty,
  input  logic               pop,
  output srs_pkg::out_word_t out_data
);
  import srs_pkg::*;

  logic      evt_valid;
  line_evt_t evt_in;
  line_evt_t evt_out;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;

  srs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .q_full   (q_full),
    .evt_valid(evt_valid),
    .evt      (evt_in)
  );

  srs_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (evt_valid),
    .wr_data(evt_in),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_data(evt_out),
    .empty  (q_empty)
  );

  srs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .evt_valid(!q_empty),
    .evt      (evt_out),
    .evt_pop  (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

// ===== src/srs_checker.sv =====
// Port-level checks for the sequence read statistics unit, bound to the top level.
module srs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input srs_pkg::out_word_t out_data
);
  import srs_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not cleared by reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty)
    else $error("waiting result dropped");

  a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> $stable(out_data))
    else $error("waiting result changed");

  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.shortest_read <= out_data.longest_read) ||
               ((&out_data.shortest_read) && (out_data.longest_read == '0)))
    else $error("shortest read exceeds longest read");

  a_len_needs_read: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_data.longest_read != '0) |-> (out_data.read_count != '0))
    else $error("read length without any read");

endmodule

bind sequence_read_statistics_unit srs_checker u_srs_checker (.*);

// ===== tb/sequence_read_statistics_unit_test.sv =====
// Self-checking testbench for the FASTA/FASTQ read statistics unit.
module sequence_read_statistics_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import srs_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 8;
  localparam logic [63:0] LEN_TOP  = {64{1'b1}} >> (64 - LEN_W);
  localparam logic [63:0] READ_TOP = {64{1'b1}} >> (64 - READ_W);
  localparam logic [63:0] BASE_TOP = {64{1'b1}} >> (64 - BASE_W);
  localparam logic [63:0] WARN_TOP = {64{1'b1}} >> (64 - WARN_W);

  typedef enum logic [1:0] {FMT_UNDECIDED, FMT_FASTA, FMT_FASTQ} format_t;
  typedef enum logic [1:0] {SEC_HEADER, SEC_SEQUENCE, SEC_QUALITY} section_t;
  typedef logic [7:0] byte_q_t[$];

  logic      clk;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_word_t  in_data = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_word_t out_data;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int words_sent = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  out_word_t expected_summaries[$];

  // Running statistics of the stream, updated per accepted word.
  format_t     fmt;
  section_t    section;
  bit          line_fresh;
  logic [7:0]  line_lead;
  logic [63:0] line_len;
  logic [63:0] read_len;
  logic [63:0] qual_left;
  bit          header_pending;
  logic [63:0] n_reads;
  logic [63:0] n_bases;
  logic [63:0] len_min;
  logic [63:0] len_max;
  logic [63:0] n_warnings;

  sequence_read_statistics_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_data(in_data),
    .empty(empty),
    .pop(pop),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] top);
    if (b >= top || a > top - b) return top;
    return a + b;
  endfunction

  function automatic void clear_tally();
    fmt = FMT_UNDECIDED;
    section = SEC_HEADER;
    line_fresh = 1'b1;
    line_lead = '0;
    line_len = '0;
    read_len = '0;
    qual_left = '0;
    header_pending = 1'b0;
    n_reads = '0;
    n_bases = '0;
    len_min = LEN_TOP;
    len_max = '0;
    n_warnings = '0;
  endfunction

  function automatic void close_read_length();
    if (read_len < len_min) len_min = read_len;
    if (read_len > len_max) len_max = read_len;
    read_len = '0;
  endfunction

  function automatic void add_bases(logic [63:0] n);
    n_bases = sat_add(n_bases, n, BASE_TOP);
    read_len = sat_add(read_len, n, LEN_TOP);
  endfunction

  function automatic void end_line();
    logic [63:0] n;
    bit has_text;
    logic [7:0] lead;
    n = line_len;
    has_text = !line_fresh;
    lead = line_lead;
    case (fmt)
      FMT_UNDECIDED: begin
        n_reads = sat_add(n_reads, 1, READ_TOP);
        read_len = '0;
        if (has_text && lead == CH_AT) begin
          fmt = FMT_FASTQ;
          section = SEC_SEQUENCE;
        end else begin
          fmt = FMT_FASTA;
        end
      end
      FMT_FASTA: begin
        if (has_text && lead == CH_GT) begin
          n_reads = sat_add(n_reads, 1, READ_TOP);
          close_read_length();
        end else begin
          add_bases(n);
        end
      end
      default: begin
        case (section)
          SEC_HEADER: begin
            if (header_pending && !(has_text && lead == CH_AT))
              n_warnings = sat_add(n_warnings, 1, WARN_TOP);
            header_pending = 1'b0;
            n_reads = sat_add(n_reads, 1, READ_TOP);
            section = SEC_SEQUENCE;
          end
          SEC_SEQUENCE: begin
            if (n == 1 && lead == CH_PLUS) begin
              qual_left = read_len;
              section = SEC_QUALITY;
            end else begin
              add_bases(n);
            end
          end
          default: begin
            if (n >= qual_left) begin
              qual_left = '0;
              close_read_length();
              header_pending = 1'b1;
              section = SEC_HEADER;
            end else begin
              qual_left = qual_left - n;
            end
          end
        endcase
      end
    endcase
    line_fresh = 1'b1;
    line_lead = '0;
    line_len = '0;
  endfunction

  function automatic void tally_word(in_word_t w);
    out_word_t s;
    if (w.action == ACT_DATA) begin
      if (w.data_byte == CH_NL) begin
        end_line();
      end else begin
        if (line_fresh) begin
          line_lead = w.data_byte;
          line_fresh = 1'b0;
        end
        line_len = sat_add(line_len, 1, LEN_TOP);
      end
    end else begin
      // flush an unterminated line, then close the read still open
      if (!line_fresh) end_line();
      if (fmt == FMT_FASTA || (fmt == FMT_FASTQ && section == SEC_QUALITY))
        close_read_length();
      s.read_count = n_reads[READ_W-1:0];
      s.base_count = n_bases[BASE_W-1:0];
      s.shortest_read = len_min[LEN_W-1:0];
      s.longest_read = len_max[LEN_W-1:0];
      s.warning_count = n_warnings[WARN_W-1:0];
      expected_summaries.push_back(s);
      clear_tally();
    end
  endfunction

  task automatic send_word(input logic act, input logic [7:0] b);
    in_word_t w;
    w.action = act;
    w.data_byte = b;
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (full);
    tally_word(w);
    words_sent++;
  endtask

  task automatic send_stream(input byte_q_t text, input logic [7:0] end_byte);
    foreach (text[i]) send_word(ACT_DATA, text[i]);
    send_word(ACT_END, end_byte);
  endtask

  function automatic logic [7:0] seq_char();
    int r;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < 70) begin
      case ($urandom_range(3))
        0: c = "A";
        1: c = "C";
        2: c = "G";
        default: c = "T";
      endcase
    end else if (r < 92) begin
      c = 8'($urandom_range(255));
      if (c == CH_NL) c = 8'hFF;
    end else begin
      case ($urandom_range(2))
        0: c = CH_AT;
        1: c = CH_GT;
        default: c = CH_PLUS;
      endcase
    end
    return c;
  endfunction

  // lead < 0 means the line starts with ordinary text
  function automatic void add_line(ref byte_q_t text, input int lead, input int len);
    if (lead >= 0) text.push_back(8'(lead));
    repeat (len) text.push_back(seq_char());
    text.push_back(CH_NL);
  endfunction

  function automatic void build_fastq(ref byte_q_t text);
    int records;
    int total;
    int left;
    int len;
    bit last;
    records = $urandom_range(1, 3);
    for (int rec = 0; rec < records; rec++) begin
      last = (rec == records - 1);
      if (rec == 0 || $urandom_range(99) < 85) add_line(text, CH_AT, $urandom_range(0, 5));
      else if ($urandom_range(1)) add_line(text, -1, 0);
      else add_line(text, seq_char(), $urandom_range(0, 4));
      total = 0;
      repeat ($urandom_range(0, 2)) begin
        len = $urandom_range(0, 7);
        add_line(text, -1, len);
        total += len;
      end
      // cut the last record short now and then
      if (last && $urandom_range(99) < 10) return;
      add_line(text, CH_PLUS, 0);
      left = total;
      do begin
        if (last && $urandom_range(99) < 8) return;
        len = $urandom_range(0, left + 2);
        add_line(text, -1, len);
        left = (len >= left) ? 0 : left - len;
      end while (left > 0);
    end
  endfunction

  function automatic void build_fasta(ref byte_q_t text);
    int reads;
    reads = $urandom_range(1, 3);
    for (int rd = 0; rd < reads; rd++) begin
      if (rd > 0 || $urandom_range(99) < 85) add_line(text, CH_GT, $urandom_range(0, 5));
      else if ($urandom_range(1)) add_line(text, -1, 0);
      else add_line(text, -1, $urandom_range(1, 6));
      repeat ($urandom_range(0, 3)) add_line(text, -1, $urandom_range(0, 10));
    end
  endfunction

  function automatic void build_noise(ref byte_q_t text);
    repeat ($urandom_range(0, 20)) begin
      if ($urandom_range(99) < 20) text.push_back(CH_NL);
      else text.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic test_empty_stream();
    byte_q_t none;
    send_stream(none, 8'h00);
  endtask

  // header-only second record: warning, unterminated line, read without a plus line
  task automatic test_fastq_warning();
    send_stream('{CH_AT, CH_NL, "A", CH_NL, CH_PLUS, CH_NL, "!", CH_NL, "x"}, 8'hFF);
  endtask

  // empty first line picks FASTA; zero, carriage return and 0xFF count as bases
  task automatic test_fasta_odd_bytes();
    send_stream('{CH_NL, 8'h00, 8'h0D, 8'hFF, CH_NL, CH_GT}, 8'h5A);
  endtask

  task automatic test_truncated_quality();
    send_stream('{CH_AT, CH_NL, "A", CH_NL, CH_PLUS, CH_NL}, 8'hA5);
  endtask

  task automatic test_random_streams(input int idle_pct, input int stall_pct,
                                     input int word_goal, input int stream_goal);
    byte_q_t text;
    int first_word;
    int streams;
    int kind;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    first_word = words_sent;
    streams = 0;
    while (words_sent - first_word < word_goal || streams < stream_goal) begin
      text.delete();
      kind = $urandom_range(99);
      if (kind < 50) build_fastq(text);
      else if (kind < 85) build_fasta(text);
      else build_noise(text);
      // drop the final newline so the last line ends with the stream
      if (text.size() > 0 && $urandom_range(99) < 20 && text[text.size()-1] == CH_NL)
        void'(text.pop_back());
      send_stream(text, 8'($urandom_range(255)));
      streams++;
    end
  endtask

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= receiver_stall_pct);
  end

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_summary
    out_word_t want;
    if (rst_n && pop && !empty) begin
      if (expected_summaries.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = expected_summaries.pop_front();
        compare_field("read_count", 64'(want.read_count), 64'(out_data.read_count));
        compare_field("base_count", 64'(want.base_count), 64'(out_data.base_count));
        compare_field("shortest_read", 64'(want.shortest_read), 64'(out_data.shortest_read));
        compare_field("longest_read", 64'(want.longest_read), 64'(out_data.longest_read));
        compare_field("warning_count", 64'(want.warning_count),
                      64'(out_data.warning_count));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_tally();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_stream();
    test_fastq_warning();
    test_fasta_odd_bytes();
    test_truncated_quality();

    test_random_streams(0, 0, 260, 8);
    test_random_streams(76, 0, 260, 8);
    test_random_streams(0, 76, 260, 8);
    test_random_streams(15, 15, 260, 8);

    push <= 1'b0;
    receiver_stall_pct = 0;
    while (expected_summaries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
